// ===== hw/rtl/signed_alu_with_divide_core_assert.svh =====
// Assertion macros for the signed ALU core
`ifndef SIGNED_ALU_WITH_DIVIDE_CORE_ASSERT_SVH
`define SIGNED_ALU_WITH_DIVIDE_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define SA_ASSERT_IMP(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("assertion failed");
// Implication whose right side is checked in the cycle after the left side holds
`define SA_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("assertion failed");
`endif

// ===== hw/rtl/sad_pkg.sv =====
// ----------------------------------------------------------------------------
// sad_pkg: shared types and constants for the signed ALU with divide
// Operation codes and default width.
// ----------------------------------------------------------------------------
`default_nettype none
package sad_pkg;
  localparam int DataWidthDefault = 32;
  localparam int OpWidth = 3;
  typedef enum logic [OpWidth-1:0] {
    OP_ADD = 3'd0, OP_INC = 3'd1, OP_MUL = 3'd2, OP_QUO = 3'd3, OP_REM = 3'd4
  } op_t;
endpackage
`default_nettype wire

// ===== hw/rtl/sad_if.sv =====
// ----------------------------------------------------------------------------
// sad_if: valid/ready channel carrying one word
// Generic payload of parameter width.
// ----------------------------------------------------------------------------
`default_nettype none
interface sad_if #(parameter int W = 8) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/signed_alu_with_divide_core.sv =====
// Each accepted input word passes the stage 0 register, the divide chain and the output register.
// Throughput: one word per cycle unless stalled; the divide is a chain of DATA_WIDTH cells,
//   one quotient bit per cell, and every operation travels the same chain.
// The whole pipeline stalls together when the output word is not taken.
// Reset (rst, synchronous) clears every valid bit; payload is not reset.
`default_nettype none
`include "signed_alu_with_divide_core_assert.svh"
module signed_alu_with_divide_core #(
  parameter int DATA_WIDTH = sad_pkg::DataWidthDefault
) (
  input wire logic clk,
  input wire logic rst,
  sad_if.sink      in_ch,
  sad_if.source    out_ch
);
  localparam int W = DATA_WIDTH;
  // side info: op(3) negq negr div ovf dbz plain_result(W) -> SW bits
  localparam int SW = 3 + W + 5;

  logic [2:0]   operation;
  logic [W-1:0] operand_a, operand_b;
  assign operation = in_ch.data[2:0];
  assign operand_a = in_ch.data[W+2:3];
  assign operand_b = in_ch.data[2*W+2:W+3];

  // Advance whenever the output slot is free or being emptied.
  logic adv;
  assign adv = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  // Stage 0: add, increment and multiply; set up the divide.
  logic [W-1:0] sum, inc, prod, ma, mb, rs;
  logic         ov0, dbz0, isdiv, min_m1;
  logic [W-1:0] mmax, lim;
  logic [2*W-1:0] pf;
  always_comb begin
    sum  = operand_a + operand_b;
    inc  = operand_a + W'(1);
    ma   = operand_a[W-1] ? W'(-operand_a) : operand_a;
    mb   = operand_b[W-1] ? W'(-operand_b) : operand_b;
    pf   = ma * mb;
    prod = W'(operand_a * operand_b);
    mmax = {1'b0, {(W-1){1'b1}}};
    lim  = (operand_a[W-1] ^ operand_b[W-1]) ? (mmax + W'(1)) : mmax;
    isdiv  = operation == sad_pkg::OP_QUO || operation == sad_pkg::OP_REM;
    min_m1 = operand_a == {1'b1, {(W-1){1'b0}}} && operand_b == {W{1'b1}};
    ov0  = 1'b0;
    dbz0 = 1'b0;
    rs   = operand_a;
    case (operation)
      sad_pkg::OP_ADD: begin
        rs  = sum;
        ov0 = (operand_a[W-1] == operand_b[W-1]) && (sum[W-1] != operand_a[W-1]);
      end
      sad_pkg::OP_INC: begin
        rs  = inc;
        ov0 = !operand_a[W-1] && inc[W-1];
      end
      sad_pkg::OP_MUL: begin
        rs  = prod;
        ov0 = (pf[2*W-1:W] != '0) || (pf[W-1:0] > lim);
      end
      sad_pkg::OP_QUO, sad_pkg::OP_REM: begin
        ov0  = min_m1;
        dbz0 = !min_m1 && operand_b == '0;
      end
      default: begin
        rs = operand_a;
      end
    endcase
  end

  logic [W-1:0]  r0, q0, d0;
  logic [SW-1:0] s0;
  logic          v0;
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= in_ch.valid;
    end
    if (adv) begin
      r0 <= '0;
      q0 <= ma;
      d0 <= (mb == '0) ? W'(1) : mb;
      s0 <= {operation, operand_a[W-1] ^ operand_b[W-1],
             operand_a[W-1], isdiv && !ov0 && !dbz0, ov0, dbz0, rs};
    end
  end

  // Divide chain: one cell per quotient bit.
  logic [W-1:0]  rr [W+1];
  logic [W-1:0]  qq [W+1];
  logic [W-1:0]  dd [W+1];
  logic [SW-1:0] ss [W+1];
  logic          vv [W+1];
  assign rr[0] = r0;
  assign qq[0] = q0;
  assign dd[0] = d0;
  assign ss[0] = s0;
  assign vv[0] = v0;
  for (genvar i = 0; i < W; i++) begin : g_cell
    sad_cell #(.W(W), .SW(SW)) u_cell (
      .clk(clk), .en(adv), .vin(vv[i]), .rin(rr[i]), .qin(qq[i]), .din(dd[i]),
      .sin(ss[i]), .vout(vv[i+1]), .rout(rr[i+1]), .qout(qq[i+1]),
      .dout(dd[i+1]), .sout(ss[i+1]), .rst(rst)
    );
  end

  // Final stage: apply signs and pick the result.
  logic [SW-1:0] sf;
  logic [2:0]    opf;
  logic          negq, negr, divf, ovf, dbzf;
  logic [W-1:0]  rsf, resf;
  always_comb begin
    sf   = ss[W];
    rsf  = sf[W-1:0];
    dbzf = sf[W];
    ovf  = sf[W+1];
    divf = sf[W+2];
    negr = sf[W+3];
    negq = sf[W+4];
    opf  = sf[SW-1:SW-3];
    resf = rsf;
    if (divf) begin
      if (opf == sad_pkg::OP_QUO) begin
        resf = negq ? W'(-qq[W]) : qq[W];
      end else begin
        resf = negr ? W'(-rr[W]) : rr[W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (adv) begin
      out_ch.valid <= vv[W];
    end
    if (adv) begin
      out_ch.data <= {ovf | dbzf, dbzf, ovf, resf};
    end
  end

  // Error is always the OR of both flags; flags never both high.
  `SA_ASSERT_IMP(a_err, clk, rst, out_ch.valid,
    out_ch.data[W+2] == (out_ch.data[W] | out_ch.data[W+1]))
  `SA_ASSERT_IMP(a_excl, clk, rst, out_ch.valid,
    !(out_ch.data[W] && out_ch.data[W+1]))
  `SA_ASSERT_NEXT(a_hold, clk, rst, out_ch.valid && !out_ch.ready, out_ch.valid)
endmodule
`default_nettype wire

// ===== hw/rtl/sad_cell.sv =====
// ----------------------------------------------------------------------------
// sad_cell: one stage of the divide chain
// Restoring step: one quotient bit per cell, words move on each cycle in which en is high.
// ----------------------------------------------------------------------------
`default_nettype none
module sad_cell #(
  parameter int W = sad_pkg::DataWidthDefault,
  parameter int SW = 8
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic          vin,
  input  wire logic [W-1:0]  rin,
  input  wire logic [W-1:0]  qin,
  input  wire logic [W-1:0]  din,
  input  wire logic [SW-1:0] sin,
  output logic               vout,
  output logic [W-1:0]       rout,
  output logic [W-1:0]       qout,
  output logic [W-1:0]       dout,
  output logic [SW-1:0]      sout,
  input  wire logic          rst
);
  logic [W:0] trial;
  logic [W:0] diff;
  always_comb begin
    trial = {rin, qin[W-1]};
    diff  = trial - {1'b0, din};
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
    if (en) begin
      rout <= diff[W] ? trial[W-1:0] : diff[W-1:0];
      qout <= {qin[W-2:0], ~diff[W]};
      dout <= din;
      sout <= sin;
    end
  end
endmodule
`default_nettype wire

// ===== dv/sad_tb_if_note.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sad_tb_types: word layouts used by the signed ALU testbench
// Input word is {operand_b, operand_a, operation} with operation in the low
// bits; output word is {error, divide_by_zero, overflow, result}.
// ----------------------------------------------------------------------------
package sad_tb_types;
  localparam int DW = 32;
  localparam int InW = sad_pkg::OpWidth + 2 * DW;
  localparam int OutW = DW + 3;

  typedef struct packed {
    logic [DW-1:0]               operand_b;
    logic [DW-1:0]               operand_a;
    logic [sad_pkg::OpWidth-1:0] operation;
  } alu_req_t;

  typedef struct packed {
    logic          error;
    logic          divide_by_zero;
    logic          overflow;
    logic [DW-1:0] result;
  } alu_rsp_t;
endpackage

// ===== dv/tb_signed_alu_with_divide_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_alu_with_divide_core: self-checking bench for the signed ALU
// Drives directed and random words through the valid/ready input, predicts
// each result word in the bench and compares it field by field at the output,
// with random bursts, random output stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_signed_alu_with_divide_core;
  localparam int DW = sad_tb_types::DW;
  localparam logic [DW-1:0] IntMin = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] IntMax = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MinusOne = {DW{1'b1}};
  localparam int RandomWords = 1430;
  // codes with no operation behind them
  localparam logic [sad_pkg::OpWidth-1:0] OpNop5 = 3'd5;
  localparam logic [sad_pkg::OpWidth-1:0] OpNop6 = 3'd6;
  localparam logic [sad_pkg::OpWidth-1:0] OpNop7 = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sad_if #(.W(sad_tb_types::InW))  in_ch ();
  sad_if #(.W(sad_tb_types::OutW)) out_ch ();

  signed_alu_with_divide_core #(.DATA_WIDTH(DW)) dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  sad_tb_types::alu_req_t pending_words[$];
  sad_tb_types::alu_rsp_t expected_results[$];
  int       fail_count = 0;
  int       taken_count = 0;
  bit       in_taken = 1'b0;

  // Build one input word.
  function automatic sad_tb_types::alu_req_t make_req(
      logic [sad_pkg::OpWidth-1:0] op, logic [DW-1:0] a, logic [DW-1:0] b);
    sad_tb_types::alu_req_t w;
    w.operation = op;
    w.operand_a = a;
    w.operand_b = b;
    return w;
  endfunction

  // Predict one result word from an input word.
  function automatic sad_tb_types::alu_rsp_t alu_predict(sad_tb_types::alu_req_t w);
    sad_tb_types::alu_rsp_t r;
    logic signed [DW-1:0]   a, b;
    logic signed [2*DW-1:0] prod;
    longint                 qa, qb;
    a = w.operand_a;
    b = w.operand_b;
    r = '{result: a, overflow: 1'b0, divide_by_zero: 1'b0, error: 1'b0};
    case (w.operation)
      sad_pkg::OP_ADD, sad_pkg::OP_INC: begin
        if (w.operation == sad_pkg::OP_INC) b = 1;
        r.result = a + b;
        r.overflow = (a[DW-1] == b[DW-1]) && (r.result[DW-1] != a[DW-1]);
      end
      sad_pkg::OP_MUL: begin
        prod = a * b;
        r.result = prod[DW-1:0];
        r.overflow = (prod != {{DW{prod[DW-1]}}, prod[DW-1:0]});
      end
      sad_pkg::OP_QUO, sad_pkg::OP_REM: begin
        if (a == IntMin && b == MinusOne) begin
          r.overflow = 1'b1;
        end else if (b == 0) begin
          r.divide_by_zero = 1'b1;
        end else begin
          qa = a;
          qb = b;
          // longint division truncates toward zero; remainder follows A
          r.result = (w.operation == sad_pkg::OP_QUO) ? DW'(qa / qb) : DW'(qa % qb);
        end
      end
      default: ;  // unused codes pass operand A through
    endcase
    r.error = r.overflow | r.divide_by_zero;
    return r;
  endfunction

  function automatic logic [DW-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return IntMin;
      1: return IntMax;
      2: return MinusOne;
      3: return '0;
      4: return DW'($urandom_range(0, 20)) - DW'(10);
      5: return DW'($urandom_range(0, 131071)) - DW'(65536);
      default: return $urandom;
    endcase
  endfunction

  // Fill the stimulus queue: directed corners first, then random words.
  initial begin
    sad_tb_types::alu_req_t w;
    logic [DW-1:0] corners[4];
    corners = '{IntMin, IntMax, MinusOne, '0};
    foreach (corners[i]) begin
      pending_words.push_back(make_req(sad_pkg::OP_ADD, corners[i], corners[(i+1)%4]));
      pending_words.push_back(make_req(sad_pkg::OP_MUL, corners[i], corners[(i+2)%4]));
    end
    pending_words.push_back(make_req(sad_pkg::OP_ADD, IntMax, DW'(1)));
    pending_words.push_back(make_req(sad_pkg::OP_INC, IntMax, '0));
    pending_words.push_back(make_req(sad_pkg::OP_INC, MinusOne, IntMin));
    pending_words.push_back(make_req(sad_pkg::OP_MUL, IntMin, MinusOne));
    pending_words.push_back(make_req(sad_pkg::OP_QUO, IntMin, MinusOne));  // overflow
    pending_words.push_back(make_req(sad_pkg::OP_REM, IntMin, MinusOne));
    pending_words.push_back(make_req(sad_pkg::OP_QUO, IntMax, '0));  // zero divisor
    pending_words.push_back(make_req(sad_pkg::OP_REM, IntMin, '0));
    pending_words.push_back(make_req(sad_pkg::OP_QUO, DW'(-7), DW'(2)));  // toward zero
    pending_words.push_back(make_req(sad_pkg::OP_REM, DW'(-7), DW'(2)));
    pending_words.push_back(make_req(sad_pkg::OP_REM, DW'(7), DW'(-2)));
    pending_words.push_back(make_req(sad_pkg::OP_QUO, IntMin, DW'(1)));
    pending_words.push_back(make_req(OpNop5, IntMin, IntMax));  // unused codes
    pending_words.push_back(make_req(OpNop6, IntMax, '0));
    pending_words.push_back(make_req(OpNop7, MinusOne, MinusOne));
    repeat (RandomWords) begin
      w.operation = ($urandom_range(0, 19) == 0)
                    ? 3'($urandom_range(OpNop5, OpNop7))
                    : 3'($urandom_range(sad_pkg::OP_ADD, sad_pkg::OP_REM));
      w.operand_a = pick_operand();
      w.operand_b = pick_operand();
      pending_words.push_back(w);
    end
  end

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
    end else if (!in_ch.valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.data <= pending_words.pop_front();
        if (burst_left == 0) begin
          // close this burst: pick its successor and maybe a gap
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall pattern, one long hold-off once more than 300 words are taken.
  int stall_mode = 0;
  int hold_cycles = 0;
  bit long_hold_done = 1'b0;
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else if (!long_hold_done && taken_count > 300) begin
      long_hold_done <= 1'b1;
      hold_cycles <= 200;
      out_ch.ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: out_ch.ready <= 1'b1;                           // free running
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        default: out_ch.ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  // Monitor: record accepted inputs, check accepted outputs.
  always @(posedge clk) begin
    sad_tb_types::alu_rsp_t got, exp_w;
    in_taken = 1'b0;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        in_taken = 1'b1;
        taken_count++;
        expected_results.push_back(alu_predict(in_ch.data));
      end
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (expected_results.size() == 0) begin
          $error("unexpected result word %h", got);
          fail_count++;
        end else begin
          exp_w = expected_results.pop_front();
          if (got.result !== exp_w.result) begin
            $error("result: expected %h actual %h", exp_w.result, got.result);
            fail_count++;
          end
          if (got.overflow !== exp_w.overflow) begin
            $error("overflow: expected %b actual %b", exp_w.overflow, got.overflow);
            fail_count++;
          end
          if (got.divide_by_zero !== exp_w.divide_by_zero) begin
            $error("divide_by_zero: expected %b actual %b",
                   exp_w.divide_by_zero, got.divide_by_zero);
            fail_count++;
          end
          if (got.error !== exp_w.error) begin
            $error("error: expected %b actual %b", exp_w.error, got.error);
            fail_count++;
          end
        end
      end
    end
  end

  // Reset, then drain: wait for all stimulus and results, then settle.
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    wait (pending_words.size() == 0 && !in_ch.valid);
    wait (expected_results.size() == 0);
    repeat (2 * DW + 10) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end
endmodule
